>>> hw/rtl/lsi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// lsi_pkg
// Shared widths, codes, types and constants of the lambda schedule
// interpolator.
// ============================================================================
package lsi_pkg;

  // Port field widths
  localparam int ACT_W      = 1;
  localparam int CH_IN_W    = 3;
  localparam int COL_IN_W   = 6;
  localparam int VAL_W      = 32;
  localparam int STEP_W     = 48;
  localparam int STATE_W    = 7;
  localparam int RATE_W     = 41;
  localparam int SIU_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 41;

  // Fixed point layout
  localparam int FRAC_W      = 40;   // fraction bits of rate and position
  localparam int F_W         = 24;   // interpolation weight bits
  localparam int FRAC_SUM_W  = 52;   // signed step * rate after saturation
  localparam int G_W         = 53;   // signed global lambda, 40 fraction bits
  localparam int LAM_SHIFT   = FRAC_W - 24;
  localparam int SAT_BIT     = 50;   // step * rate saturates at 2^50

  // Shared multiplier
  localparam int MUL_OP_W    = 48;
  localparam int MUL_CHUNK_W = 24;
  localparam int MUL_P_W     = 2 * MUL_OP_W;
  localparam logic [2:0] MUL_LAST = 3'd4;

  // Item action codes
  localparam logic [ACT_W-1:0] ACT_WRITE = 1'b0;
  localparam logic [ACT_W-1:0] ACT_EVAL  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RATE         = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_STATE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_LAMBDA = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STATES       = 2'd3;

  // Reset values and fixed constants
  localparam logic [STATE_W-1:0] START_STATE_NONE = 7'h7F;
  localparam logic [VAL_W-1:0]   NEG_ONE_Q24      = 32'hFF00_0000;
  localparam logic signed [VAL_W-1:0] Q24_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] Q24_MIN     = -32'sh7FFF_FFFF - 32'sd1;
  localparam logic signed [FRAC_SUM_W-1:0] FRAC_LO = -(52'sd1 <<< 46);
  localparam logic signed [FRAC_SUM_W-1:0] FRAC_HI = 52'sd1 <<< FRAC_W;
  localparam logic signed [G_W-1:0] G_ONE          = 53'sd1 <<< FRAC_W;
  localparam logic [G_W-1:0] LAM_ROUND             = 53'd1 << (LAM_SHIFT - 1);

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MUL_STEP,
    ST_PREP,
    ST_MUL_POS,
    ST_POS,
    ST_READ,
    ST_LOAD,
    ST_EMIT
  } lsi_state_t;

  // Command to the shared multiplier
  typedef struct packed {
    logic                start;
    logic [MUL_OP_W-1:0] a;
    logic [MUL_OP_W-1:0] b;
  } mul_cmd_t;

endpackage : lsi_pkg
`default_nettype wire

>>> hw/rtl/lsi_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// lsi_mul
// Sequential 48 x 48 unsigned multiplier built from one 24 x 24 unit; four
// partial products are formed, registered and accumulated.
// ============================================================================
module lsi_mul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lsi_pkg::mul_cmd_t            cmd,
  output logic                         done,
  output logic [lsi_pkg::MUL_P_W-1:0]  prod
);
  import lsi_pkg::*;

  logic [MUL_OP_W-1:0]      a_r;
  logic [MUL_OP_W-1:0]      b_r;
  logic [MUL_P_W-1:0]       acc_r;
  logic [2*MUL_CHUNK_W-1:0] pp_r;
  logic [1:0]               pp_sh_r;
  logic                     pp_vld_r;
  logic                     busy_r;
  logic                     done_r;
  logic [2:0]               cnt_r;
  logic [MUL_CHUNK_W-1:0]   a_chunk;
  logic [MUL_CHUNK_W-1:0]   b_chunk;
  logic [MUL_P_W-1:0]       pp_shifted;

  // Pick the chunk pair for this step
  assign a_chunk = cnt_r[0] ? a_r[MUL_OP_W-1:MUL_CHUNK_W] : a_r[MUL_CHUNK_W-1:0];
  assign b_chunk = cnt_r[1] ? b_r[MUL_OP_W-1:MUL_CHUNK_W] : b_r[MUL_CHUNK_W-1:0];

  // Align the registered partial product
  always_comb begin
    case (pp_sh_r)
      2'd0:    pp_shifted = MUL_P_W'(pp_r);
      2'd1:    pp_shifted = MUL_P_W'(pp_r) << MUL_CHUNK_W;
      2'd2:    pp_shifted = MUL_P_W'(pp_r) << (2 * MUL_CHUNK_W);
      default: pp_shifted = '0;
    endcase
  end

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      cnt_r    <= '0;
      pp_vld_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r   <= 1'b1;
        cnt_r    <= '0;
        pp_vld_r <= 1'b0;
      end else if (busy_r) begin
        if (cnt_r != MUL_LAST) begin
          cnt_r    <= cnt_r + 3'd1;
          pp_vld_r <= 1'b1;
        end else begin
          pp_vld_r <= 1'b0;
          busy_r   <= 1'b0;
          done_r   <= 1'b1;
        end
      end
    end
  end

  // Form and accumulate partial products
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      a_r   <= cmd.a;
      b_r   <= cmd.b;
      acc_r <= '0;
    end else if (busy_r) begin
      if (cnt_r != MUL_LAST) begin
        pp_r    <= a_chunk * b_chunk;
        pp_sh_r <= {1'b0, cnt_r[0]} + {1'b0, cnt_r[1]};
      end
      if (pp_vld_r) begin
        acc_r <= acc_r + pp_shifted;
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule : lsi_mul
`default_nettype wire

>>> hw/rtl/lsi_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// lsi_table
// Schedule table memory: one write port, two read ports with registered
// read data.
// ============================================================================
module lsi_table #(
  parameter int ADDR_W = 9
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [ADDR_W-1:0]          waddr,
  input  logic [lsi_pkg::VAL_W-1:0]  wdata,
  input  logic [ADDR_W-1:0]          raddr_a,
  input  logic [ADDR_W-1:0]          raddr_b,
  output logic [lsi_pkg::VAL_W-1:0]  rdata_a,
  output logic [lsi_pkg::VAL_W-1:0]  rdata_b
);
  import lsi_pkg::*;

  localparam int DEPTH = 1 << ADDR_W;

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rdata_a_r;
  logic [VAL_W-1:0] rdata_b_r;

  // Write one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read both neighbors
  always_ff @(posedge clk) begin
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule : lsi_table
`default_nettype wire

>>> hw/rtl/lsi_lerp.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// lsi_lerp
// Linear interpolation a + round((b - a) * f / 2^24) with Q8.24 saturation;
// the product is registered before the final add.
// ============================================================================
module lsi_lerp (
  input  logic                              clk,
  input  logic                              load,
  input  logic signed [lsi_pkg::VAL_W-1:0]  a,
  input  logic signed [lsi_pkg::VAL_W-1:0]  b,
  input  logic [lsi_pkg::F_W-1:0]           f,
  output logic signed [lsi_pkg::VAL_W-1:0]  result
);
  import lsi_pkg::*;

  localparam int DIFF_W = VAL_W + 1;
  localparam int PROD_W = DIFF_W + F_W + 1;
  localparam int D_W    = PROD_W - F_W;
  localparam int SUM_W  = D_W + 1;
  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (F_W - 1);

  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [VAL_W-1:0]  a_r;
  logic signed [PROD_W-1:0] rounded;
  logic signed [D_W-1:0]    delta;
  logic signed [SUM_W-1:0]  sum;

  assign diff = $signed({b[VAL_W-1], b}) - $signed({a[VAL_W-1], a});

  // Register the weighted difference
  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= diff * $signed({1'b0, f});
      a_r    <= a;
    end
  end

  // Round half up, add the left value and saturate
  always_comb begin
    rounded = prod_r + HALF;
    delta   = rounded[PROD_W-1:F_W];
    sum     = SUM_W'(a_r) + SUM_W'(delta);
    if (sum > SUM_W'(Q24_MAX)) begin
      result = Q24_MAX;
    end else if (sum < SUM_W'(Q24_MIN)) begin
      result = Q24_MIN;
    end else begin
      result = sum[VAL_W-1:0];
    end
  end

endmodule : lsi_lerp
`default_nettype wire

>>> hw/rtl/lambda_schedule_interpolator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// lambda_schedule_interpolator_core
// Per-channel lambda from a schedule table by linear interpolation.
// ============================================================================
// A write transaction (action 0) stores one Q8.24 table entry when its
// channel and column are in range. An evaluate transaction (action 1)
// returns NUM_CHANNELS results in channel order, last set on the final one.
// A nonzero rate first takes one or two passes through the shared
// multiplier (step * rate, then a lambda or step term * (states - 1) for
// the position); each channel then takes a table read of both neighbors, a
// product step and an emit step, or only an emit step for a constant
// result. in_stall is high from evaluate acceptance until the last result
// is in the output register, so a new transaction is taken while that
// result still waits. The table is not cleared after reset: entries must
// be written before they are evaluated.
// ============================================================================
module lambda_schedule_interpolator_core #(
  parameter int NUM_CHANNELS = 7,
  parameter int MAX_STATES   = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [lsi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lsi_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [lsi_pkg::ACT_W-1:0]         in_action,
  input  logic [lsi_pkg::CH_IN_W-1:0]       in_channel_index,
  input  logic [lsi_pkg::COL_IN_W-1:0]      in_column_index,
  input  logic signed [lsi_pkg::VAL_W-1:0]  in_entry_value,
  input  logic [lsi_pkg::STEP_W-1:0]        in_step_number,
  input  logic signed [lsi_pkg::STATE_W-1:0] in_current_state,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [lsi_pkg::CH_IN_W-1:0]       out_channel_out,
  output logic signed [lsi_pkg::VAL_W-1:0]  out_lambda_value,
  output logic                              out_state_invalid,
  output logic                              out_last
);
  import lsi_pkg::*;

  localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int COL_W  = $clog2(MAX_STATES);
  localparam int NW     = $clog2(MAX_STATES + 1);
  localparam int SW     = (NW > STATE_W) ? NW : STATE_W;
  localparam int ADDR_W = CH_W + COL_W;
  localparam int POS_W  = 49 + NW;
  localparam logic [CH_W-1:0] CH_LAST = CH_W'(NUM_CHANNELS - 1);

  // configuration registers
  logic [RATE_W-1:0]  rate_r;
  logic [STATE_W-1:0] sst_r;
  logic [VAL_W-1:0]   slam_r;
  logic [SIU_W-1:0]   siu_r;

  // sequencer
  lsi_state_t state_r, state_nxt;
  logic [CH_W-1:0] ch_r;
  logic            in_acc;
  logic            out_free;
  logic            out_load;
  logic            lerp_load;
  mul_cmd_t        mul_cmd;
  logic            mul_done;
  logic [MUL_P_W-1:0] mul_prod;

  // evaluation registers
  logic [STEP_W-1:0]               step_r;
  logic [STATE_W-1:0]              cur_r;
  logic                            const_mode_r;
  logic [VAL_W-1:0]                const_val_r;
  logic                            const_inv_r;
  logic signed [FRAC_SUM_W-1:0]    frac_r;
  logic                            neg_r;
  logic signed [POS_W-1:0]         pos_raw_r;
  logic [COL_W-1:0]                left_r;
  logic [COL_W-1:0]                right_r;
  logic [F_W-1:0]                  f_r;

  // output register
  logic                            out_valid_r;
  logic [CH_IN_W-1:0]              out_ch_r;
  logic signed [VAL_W-1:0]         out_val_r;
  logic                            out_inv_r;
  logic                            out_last_r;

  // derived values
  logic [NW-1:0]                   n;
  logic [SW-1:0]                   siu_ext;
  logic [NW-1:0]                   nm1;
  logic                            n_zero;
  logic                            n_one;
  logic                            rate_zero;
  logic [RATE_W-1:0]               rate_mag;
  logic [RATE_W:0]                 rate_neg;
  logic [STATE_W-1:0]              sel;
  logic                            sel_ok;
  logic                            slam_set;
  logic                            fm_sat;
  logic [SAT_BIT:0]                fm;
  logic signed [FRAC_SUM_W-1:0]    frac_nxt;
  logic signed [G_W-1:0]           frac_ext;
  logic signed [G_W-1:0]           init_slam;
  logic signed [G_W-1:0]           g0;
  logic [G_W-1:0]                  g0_rnd;
  logic [G_W-LAM_SHIFT-1:0]        r0;
  logic [VAL_W-1:0]                lam0;
  logic signed [G_W-1:0]           g1;
  logic signed [G_W-1:0]           g1c;
  logic signed [FRAC_SUM_W-1:0]    xabs;
  logic signed [POS_W-1:0]         sst_term;
  logic signed [POS_W-1:0]         mag_term;
  logic signed [POS_W-1:0]         pos_sum;
  logic signed [POS_W-1:0]         pos_ub;
  logic signed [POS_W-1:0]         pos_c;
  logic [COL_W-1:0]                left_c;

  // table and interpolator
  logic                            tbl_we;
  logic [ADDR_W-1:0]               tbl_waddr;
  logic [VAL_W-1:0]                rdata_a;
  logic [VAL_W-1:0]                rdata_b;
  logic signed [VAL_W-1:0]         lerp_res;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Column count in use, limited to the table size
  always_comb begin
    siu_ext = SW'(siu_r);
    n       = (siu_ext > SW'(MAX_STATES)) ? NW'(MAX_STATES) : NW'(siu_ext);
    nm1     = n - NW'(1);
    n_zero  = (n == '0);
    n_one   = (n == NW'(1));
  end

  // Rate magnitude and chosen state for the zero-rate path
  always_comb begin
    rate_zero = (rate_r == '0);
    rate_neg  = -{rate_r[RATE_W-1], rate_r};
    rate_mag  = rate_r[RATE_W-1] ? rate_neg[RATE_W-1:0] : rate_r;
    sel       = cur_r[STATE_W-1] ? sst_r : cur_r;
    sel_ok    = SW'(sel[STATE_W-2:0]) < SW'(n);
    slam_set  = $signed(slam_r) > $signed(NEG_ONE_Q24);
  end

  // Saturate step * rate and apply the sign
  always_comb begin
    fm_sat   = (|mul_prod[MUL_P_W-1:SAT_BIT+1]) ||
               (mul_prod[SAT_BIT] && (|mul_prod[SAT_BIT-1:0]));
    fm       = fm_sat ? ((SAT_BIT+1)'(1) << SAT_BIT) : mul_prod[SAT_BIT:0];
    frac_nxt = rate_r[RATE_W-1] ? -$signed({1'b0, fm}) : $signed({1'b0, fm});
  end

  // Global lambda forms for the no-table and start-lambda cases
  always_comb begin
    frac_ext  = {frac_r[FRAC_SUM_W-1], frac_r};
    init_slam = $signed({{(G_W-VAL_W-LAM_SHIFT){slam_r[VAL_W-1]}}, slam_r,
                         {LAM_SHIFT{1'b0}}});
    // no table: clamp at zero, round half up to Q8.24
    g0     = ((sst_r[STATE_W-1] && slam_set) ? init_slam : '0) + frac_ext;
    g0_rnd = (g0 < 0) ? LAM_ROUND : ($unsigned(g0) + LAM_ROUND);
    r0     = g0_rnd[G_W-1:LAM_SHIFT];
    lam0   = (|r0[G_W-LAM_SHIFT-1:VAL_W-1]) ? Q24_MAX : r0[VAL_W-1:0];
    // start lambda with a table: clamp to [0, 1]
    g1  = (slam_set ? init_slam : '0) + frac_ext;
    g1c = (g1 < 0) ? '0 : ((g1 > G_ONE) ? G_ONE : g1);
    // start state: bound the step term where the position clamp decides
    if (frac_r < FRAC_LO) begin
      xabs = -FRAC_LO;
    end else if (frac_r > FRAC_HI) begin
      xabs = FRAC_HI;
    end else if (frac_r < 0) begin
      xabs = -frac_r;
    end else begin
      xabs = frac_r;
    end
  end

  // Position from the second product, clamped to the columns in use
  always_comb begin
    sst_term = sst_r[STATE_W-1] ? '0
             : $signed(POS_W'(sst_r[STATE_W-2:0]) << FRAC_W);
    mag_term = $signed(mul_prod[POS_W-1:0]);
    pos_sum  = sst_term + (neg_r ? -mag_term : mag_term);
    pos_ub   = $signed(POS_W'(nm1) << FRAC_W);
    if (pos_raw_r < 0) begin
      pos_c = '0;
    end else if (pos_raw_r > pos_ub) begin
      pos_c = pos_ub;
    end else begin
      pos_c = pos_raw_r;
    end
    left_c = pos_c[FRAC_W +: COL_W];
  end

  // Next state and strobes
  always_comb begin
    state_nxt = state_r;
    mul_cmd   = '0;
    lerp_load = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_action == ACT_EVAL) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (rate_zero) begin
          if (sel[STATE_W-1] || !sel_ok) begin
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_READ;
          end
        end else begin
          mul_cmd.start = 1'b1;
          mul_cmd.a     = MUL_OP_W'(rate_mag);
          mul_cmd.b     = step_r;
          state_nxt     = ST_MUL_STEP;
        end
      end
      ST_MUL_STEP: begin
        if (mul_done) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        if (n_zero) begin
          state_nxt = ST_EMIT;
        end else if (!sst_r[STATE_W-1] && n_one) begin
          state_nxt = ST_READ;
        end else begin
          mul_cmd.start = 1'b1;
          mul_cmd.a     = sst_r[STATE_W-1] ? MUL_OP_W'(g1c) : MUL_OP_W'(xabs);
          mul_cmd.b     = MUL_OP_W'(nm1);
          state_nxt     = ST_MUL_POS;
        end
      end
      ST_MUL_POS: begin
        if (mul_done) begin
          state_nxt = ST_POS;
        end
      end
      ST_POS: begin
        state_nxt = ST_READ;
      end
      ST_READ: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        lerp_load = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (ch_r == CH_LAST) begin
            state_nxt = ST_IDLE;
          end else if (const_mode_r) begin
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
      rate_r      <= '0;
      sst_r       <= START_STATE_NONE;
      slam_r      <= NEG_ONE_Q24;
      siu_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_acc && in_action == ACT_EVAL) begin
        ch_r <= '0;
      end else if (out_load) begin
        ch_r <= ch_r + CH_W'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_RATE:         rate_r <= cfg_data[RATE_W-1:0];
          CFG_START_STATE:  sst_r  <= cfg_data[STATE_W-1:0];
          CFG_START_LAMBDA: slam_r <= cfg_data[VAL_W-1:0];
          CFG_STATES:       siu_r  <= cfg_data[SIU_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Evaluation datapath
  always_ff @(posedge clk) begin
    if (in_acc && in_action == ACT_EVAL) begin
      step_r <= in_step_number;
      cur_r  <= in_current_state;
    end
    case (state_r)
      ST_DECIDE: begin
        if (rate_zero) begin
          const_mode_r <= sel[STATE_W-1] || !sel_ok;
          const_val_r  <= sel[STATE_W-1] ? slam_r : '0;
          const_inv_r  <= !sel[STATE_W-1];
          left_r       <= COL_W'(sel[STATE_W-2:0]);
          right_r      <= COL_W'(sel[STATE_W-2:0]);
          f_r          <= '0;
        end else begin
          const_mode_r <= 1'b0;
        end
      end
      ST_MUL_STEP: begin
        if (mul_done) begin
          frac_r <= frac_nxt;
        end
      end
      ST_PREP: begin
        if (n_zero) begin
          const_mode_r <= 1'b1;
          const_val_r  <= lam0;
          const_inv_r  <= 1'b0;
        end else if (!sst_r[STATE_W-1] && n_one) begin
          left_r  <= '0;
          right_r <= '0;
          f_r     <= '0;
        end else begin
          neg_r <= !sst_r[STATE_W-1] && (frac_r < 0);
        end
      end
      ST_MUL_POS: begin
        if (mul_done) begin
          pos_raw_r <= pos_sum;
        end
      end
      ST_POS: begin
        left_r  <= left_c;
        right_r <= (left_c == COL_W'(nm1)) ? left_c : left_c + COL_W'(1);
        f_r     <= pos_c[FRAC_W-1 -: F_W];
      end
      default: ;
    endcase
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch_r   <= CH_IN_W'(ch_r);
      out_val_r  <= const_mode_r ? $signed(const_val_r) : lerp_res;
      out_inv_r  <= const_mode_r && const_inv_r;
      out_last_r <= (ch_r == CH_LAST);
    end
  end

  // Table write from a write transaction within range
  assign tbl_we = in_acc && (in_action == ACT_WRITE) &&
                  (int'(in_channel_index) < NUM_CHANNELS) &&
                  (int'(in_column_index) < MAX_STATES);
  assign tbl_waddr = {CH_W'(in_channel_index), COL_W'(in_column_index)};

  lsi_table #(
    .ADDR_W (ADDR_W)
  ) u_table (
    .clk     (clk),
    .we      (tbl_we),
    .waddr   (tbl_waddr),
    .wdata   (in_entry_value),
    .raddr_a ({ch_r, left_r}),
    .raddr_b ({ch_r, right_r}),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  lsi_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (mul_cmd),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  lsi_lerp u_lerp (
    .clk    (clk),
    .load   (lerp_load),
    .a      ($signed(rdata_a)),
    .b      ($signed(rdata_b)),
    .f      (f_r),
    .result (lerp_res)
  );

  assign out_valid         = out_valid_r;
  assign out_channel_out   = out_ch_r;
  assign out_lambda_value  = out_val_r;
  assign out_state_invalid = out_inv_r;
  assign out_last          = out_last_r;

endmodule : lambda_schedule_interpolator_core
`default_nettype wire

>>> hw/rtl/lsi_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// lsi_checker
// Port-level checks of the lambda schedule interpolator, bound to the core.
// ============================================================================
module lsi_checker #(
  parameter int NUM_CHANNELS = 7
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic [lsi_pkg::ACT_W-1:0]         in_action,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [lsi_pkg::CH_IN_W-1:0]       out_channel_out,
  input logic signed [lsi_pkg::VAL_W-1:0]  out_lambda_value,
  input logic                              out_state_invalid,
  input logic                              out_last
);
  import lsi_pkg::*;

  localparam logic [CH_IN_W-1:0] LAST_CH = CH_IN_W'(NUM_CHANNELS - 1);

  logic [CH_IN_W-1:0] exp_ch_r;

  // Track the channel expected next
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_ch_r <= '0;
    end else if (out_valid && !out_stall) begin
      exp_ch_r <= out_last ? '0 : out_channel_out + CH_IN_W'(1);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_lambda_value) &&
      $stable(out_channel_out))
    else $error("stalled result transaction changed");

  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_action == ACT_EVAL |=> in_stall)
    else $error("input not stalled after an evaluate transaction");

  a_ch_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_channel_out == exp_ch_r)
    else $error("result channel out of order");

  a_last_ch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_last == (out_channel_out == LAST_CH))
    else $error("last flag does not mark the final channel");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_state_invalid |-> out_lambda_value == '0)
    else $error("invalid state with nonzero lambda");

endmodule : lsi_checker

bind lambda_schedule_interpolator_core lsi_checker #(
  .NUM_CHANNELS (NUM_CHANNELS)
) u_lsi_checker (.*);
`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the lambda schedule interpolator core.
// ============================================================================
// A directed list walks the reset state, the table write path, the step
// product saturation, the clamps and the state selection, then seven random
// phases change the registers and mix table writes with evaluations. Every
// evaluation is predicted per channel and checked in order against the
// results; table entries are always loaded before an evaluation reads them.
// ============================================================================
module tb_top;
  import lsi_pkg::*;

  localparam int NCH           = 7;
  localparam int NST           = 64;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 3000;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AT       = 200;
  localparam int PHASE_ITEMS   = 50;
  localparam longint Q40_ONE   = 64'sd1 <<< FRAC_W;
  localparam longint PROD_CAP  = 64'sd1 <<< SAT_BIT;

  typedef struct packed {
    logic [CH_IN_W-1:0] ch;
    logic signed [VAL_W-1:0] lam;
    logic inv;
    logic last;
  } lambda_result_t;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic [CH_IN_W-1:0] ch;
    logic [COL_IN_W-1:0] col;
    logic [VAL_W-1:0] val;
    logic [STEP_W-1:0] step;
    logic [STATE_W-1:0] cur;
  } sched_txn_t;

  typedef struct {
    bit reconfig;
    logic [RATE_W-1:0] rate;
    logic [STATE_W-1:0] sst;
    logic [VAL_W-1:0] slam;
    logic [SIU_W-1:0] siu;
    sched_txn_t txn;
    bit typed;
    logic [VAL_W-1:0] want_lam;
    bit want_inv;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ACT_W-1:0] in_action = '0;
  logic [CH_IN_W-1:0] in_channel_index = '0;
  logic [COL_IN_W-1:0] in_column_index = '0;
  logic signed [VAL_W-1:0] in_entry_value = '0;
  logic [STEP_W-1:0] in_step_number = '0;
  logic signed [STATE_W-1:0] in_current_state = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CH_IN_W-1:0] out_channel_out;
  logic signed [VAL_W-1:0] out_lambda_value;
  logic out_state_invalid;
  logic out_last;

  // Predictor state: schedule table, written marks and register copies
  logic signed [VAL_W-1:0] sched_mem [NCH][NST];
  bit sched_written [NCH][NST];
  logic signed [RATE_W-1:0] rate_q = '0;
  logic signed [STATE_W-1:0] start_state_q = START_STATE_NONE;
  logic signed [VAL_W-1:0] start_lambda_q = NEG_ONE_Q24;
  logic [SIU_W-1:0] states_q = '0;

  lambda_result_t lambda_calc [NCH];
  lambda_result_t pending_lambdas [$];
  int unread_q [$];
  plan_row_t plan_q [$];

  int err_count = 0;
  int results_seen = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  int burst_left = 0;
  bit hold_done = 1'b0;
  bit calm = 1'b0;

  lambda_schedule_interpolator_core #(
    .NUM_CHANNELS(NCH),
    .MAX_STATES(NST)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_action(in_action),
    .in_channel_index(in_channel_index),
    .in_column_index(in_column_index),
    .in_entry_value(in_entry_value),
    .in_step_number(in_step_number),
    .in_current_state(in_current_state),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_channel_out(out_channel_out),
    .out_lambda_value(out_lambda_value),
    .out_state_invalid(out_state_invalid),
    .out_last(out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic signed [VAL_W-1:0] sat_q24(longint v);
    if (v > longint'(Q24_MAX)) return Q24_MAX;
    if (v < longint'(Q24_MIN)) return Q24_MIN;
    return v[VAL_W-1:0];
  endfunction

  // Read one table entry; note entries that were never loaded
  function automatic longint read_entry(int ch, int col);
    if (!sched_written[ch][col]) unread_q.push_back(ch * NST + col);
    return longint'(sched_mem[ch][col]);
  endfunction

  // Compute the per-channel lambdas of one evaluation into lambda_calc
  function automatic void predict_lambdas(logic [STEP_W-1:0] step,
                                          logic signed [STATE_W-1:0] cur);
    longint n, rate, sst, slam, sel, frac, g, pos, left, right, f24, a, b, d;
    logic [95:0] prod;
    logic [RATE_W-1:0] mag;
    n = (states_q > NST) ? NST : states_q;
    rate = longint'(rate_q);
    sst = longint'(start_state_q);
    slam = longint'(start_lambda_q);
    for (int c = 0; c < NCH; c++) begin
      lambda_calc[c].ch = 3'(c);
      lambda_calc[c].lam = '0;
      lambda_calc[c].inv = 1'b0;
      lambda_calc[c].last = (c == NCH - 1);
    end

    // Zero rate: pick a column, or pass the start lambda through
    if (rate == 0) begin
      sel = (longint'(cur) >= 0) ? longint'(cur) : sst;
      for (int c = 0; c < NCH; c++) begin
        if (sel < 0) lambda_calc[c].lam = start_lambda_q;
        else if (sel < n) lambda_calc[c].lam = sat_q24(read_entry(c, int'(sel)));
        else lambda_calc[c].inv = 1'b1;
      end
      return;
    end

    // Step product, saturated in magnitude
    mag = (rate < 0) ? RATE_W'(-rate) : RATE_W'(rate);
    prod = mag * step;
    frac = (prod > 96'(PROD_CAP)) ? PROD_CAP : longint'(prod[63:0]);
    if (rate < 0) frac = -frac;

    // No table: clamp at zero, round to Q8.24
    if (n == 0) begin
      g = (sst < 0 && slam > -16777216) ? slam * 65536 : 0;
      g += frac;
      if (g < 0) g = 0;
      g = (g + 32768) >>> 16;
      for (int c = 0; c < NCH; c++) lambda_calc[c].lam = sat_q24(g);
      return;
    end

    // Position in columns, 40 fraction bits
    if (sst >= 0) begin
      pos = (n > 1) ? sst * Q40_ONE + frac * (n - 1) : 0;
    end else begin
      g = (slam > -16777216) ? slam * 65536 : 0;
      g += frac;
      if (g < 0) g = 0;
      if (g > Q40_ONE) g = Q40_ONE;
      pos = g * (n - 1);
    end
    if (pos < 0) pos = 0;
    if (pos > (n - 1) * Q40_ONE) pos = (n - 1) * Q40_ONE;
    left = pos >>> FRAC_W;
    if (left > n - 1) left = n - 1;
    right = (left == n - 1) ? left : left + 1;
    f24 = (pos & (Q40_ONE - 1)) >>> 16;

    // Blend neighbors with round half up
    for (int c = 0; c < NCH; c++) begin
      a = read_entry(c, int'(left));
      b = read_entry(c, int'(right));
      d = ((b - a) * f24 + (64'sd1 <<< 23)) >>> 24;
      lambda_calc[c].lam = sat_q24(a + d);
    end
  endfunction

  function automatic logic [VAL_W-1:0] rand_entry();
    case ($urandom_range(0, 15))
      0: return Q24_MAX;
      1: return Q24_MIN;
      2, 3, 4, 5, 6, 7: return $urandom_range(0, 32'h0200_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_cfg(logic [RATE_W-1:0] rate, logic [STATE_W-1:0] sst,
                                  logic [VAL_W-1:0] slam, logic [SIU_W-1:0] siu);
    plan_row_t r;
    r = '{default: '0};
    r.reconfig = 1'b1;
    r.rate = rate;
    r.sst = sst;
    r.slam = slam;
    r.siu = siu;
    plan_q.push_back(r);
  endfunction

  function automatic void add_write(logic [CH_IN_W-1:0] ch, logic [COL_IN_W-1:0] col,
                                    logic [VAL_W-1:0] val);
    plan_row_t r;
    r = '{default: '0};
    r.txn = {ACT_WRITE, ch, col, val, 48'h5555_AAAA_5555, 7'h2A};
    plan_q.push_back(r);
  endfunction

  function automatic void add_eval(logic [STEP_W-1:0] step, logic [STATE_W-1:0] cur);
    plan_row_t r;
    r = '{default: '0};
    r.txn = {ACT_EVAL, 3'd5, 6'h15, 32'hA5A5_5A5A, step, cur};
    plan_q.push_back(r);
  endfunction

  function automatic void add_checked_eval(logic [STEP_W-1:0] step, logic [STATE_W-1:0] cur,
                                           logic [VAL_W-1:0] lam, bit inv);
    plan_row_t r;
    r = '{default: '0};
    r.txn = {ACT_EVAL, 3'd2, 6'h2A, 32'h5A5A_A5A5, step, cur};
    r.typed = 1'b1;
    r.want_lam = lam;
    r.want_inv = inv;
    plan_q.push_back(r);
  endfunction

  // Offer one transaction, hold it until taken, then log what it implies
  task automatic offer_txn(sched_txn_t t, bit typed, logic [VAL_W-1:0] want_lam, bit want_inv);
    in_action <= t.act;
    in_channel_index <= t.ch;
    in_column_index <= t.col;
    in_entry_value <= t.val;
    in_step_number <= t.step;
    in_current_state <= t.cur;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (t.act == ACT_WRITE) begin
      if (t.ch < NCH) begin
        sched_mem[t.ch][t.col] = t.val;
        sched_written[t.ch][t.col] = 1'b1;
      end
    end else begin
      predict_lambdas(t.step, $signed(t.cur));
      for (int c = 0; c < NCH; c++) begin
        if (typed) begin
          lambda_calc[c].lam = want_lam;
          lambda_calc[c].inv = want_inv;
        end
        pending_lambdas.push_back(lambda_calc[c]);
      end
    end
  endtask

  // Load every table entry the coming evaluation would read
  task automatic load_missing(logic [STEP_W-1:0] step, logic signed [STATE_W-1:0] cur);
    int gaps [$];
    sched_txn_t w;
    unread_q.delete();
    predict_lambdas(step, cur);
    gaps = unread_q;
    foreach (gaps[i]) begin
      if (!sched_written[gaps[i] / NST][gaps[i] % NST]) begin
        w = {ACT_WRITE, 3'(gaps[i] / NST), 6'(gaps[i] % NST), rand_entry(),
             48'(rand64()), 7'($urandom)};
        offer_txn(w, 1'b0, '0, 1'b0);
      end
    end
  endtask

  task automatic sender_gap();
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // Drain the block, then write all four registers
  task automatic apply_config(logic [RATE_W-1:0] rate, logic [STATE_W-1:0] sst,
                              logic [VAL_W-1:0] slam, logic [SIU_W-1:0] siu);
    in_valid <= 1'b0;
    while (pending_lambdas.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(CFG_RATE, CFG_DATA_W'(rate));
    write_reg(CFG_START_STATE, CFG_DATA_W'(sst));
    write_reg(CFG_START_LAMBDA, CFG_DATA_W'(slam));
    write_reg(CFG_STATES, CFG_DATA_W'(siu));
    cfg_we <= 1'b0;
    rate_q = rate;
    start_state_q = sst;
    start_lambda_q = slam;
    states_q = siu;
  endtask

  // One random phase: new registers, then writes and evaluations
  task automatic random_phase(int count);
    logic signed [RATE_W-1:0] rate;
    logic [STATE_W-1:0] sst;
    logic [SIU_W-1:0] siu;
    logic [VAL_W-1:0] slam;
    sched_txn_t t;
    longint rl;
    longint unsigned cap;
    int n;
    case ($urandom_range(0, 9))
      0, 1, 2: rate = '0;
      3: rate = $urandom_range(0, 1) ? 41'h0FF_FFFF_FFFF : 41'h100_0000_0000;
      default: rate = RATE_W'(rand64()) >>> $urandom_range(0, 40);
    endcase
    sst = $urandom_range(0, 1) ? START_STATE_NONE : 7'($urandom_range(0, 63));
    case ($urandom_range(0, 5))
      0: slam = NEG_ONE_Q24;
      1, 2: slam = $urandom;
      default: slam = $urandom_range(0, 32'h0100_0000);
    endcase
    case ($urandom_range(0, 7))
      0: siu = 7'd0;
      1: siu = 7'd1;
      2: siu = 7'd64;
      default: siu = 7'($urandom_range(2, 64));
    endcase
    apply_config(rate, sst, slam, siu);
    n = siu;
    rl = longint'(rate);

    for (int i = 0; i < count; i++) begin
      t = {ACT_EVAL, 3'($urandom), 6'($urandom), 32'($urandom), 48'(rand64()), 7'($urandom)};
      if ($urandom_range(0, 9) < 3) begin
        t.act = ACT_WRITE;
        t.ch = ($urandom_range(0, 9) == 0) ? 3'd7 : 3'($urandom_range(0, NCH - 1));
        t.val = rand_entry();
      end else begin
        // Steps that sweep the position across the table dominate
        case ($urandom_range(0, 9))
          0: t.step = '0;
          1: t.step = '1;
          2, 3: t.step = $urandom_range(0, 65535);
          4: t.step = 48'(rand64());
          default: begin
            if (rl == 0) begin
              t.step = $urandom_range(0, 1000);
            end else begin
              cap = Q40_ONE / ((rl < 0) ? -rl : rl);
              if (cap > (64'd1 << 46)) cap = 64'd1 << 46;
              t.step = 48'(rand64() % (2 * cap + 1));
            end
          end
        endcase
        if ($urandom_range(0, 7) == 0) t.cur = 7'h7F;
        else if (n > 0 && $urandom_range(0, 4) != 0) t.cur = 7'($urandom_range(0, n - 1));
        else t.cur = 7'($urandom_range(0, 63));
        load_missing(t.step, $signed(t.cur));
      end
      offer_txn(t, 1'b0, '0, 1'b0);
      sender_gap();
    end
  endtask

  // Stimulus: directed list, random phases, then drain
  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Reset registers: no state, no table
    add_checked_eval(48'd0, 7'h7F, NEG_ONE_Q24, 1'b0);
    add_checked_eval(48'd77, 7'd0, 32'd0, 1'b1);
    add_checked_eval('1, 7'd63, 32'd0, 1'b1);
    // Out-of-range channel is dropped; extreme entries
    add_write(3'd7, 6'd0, 32'h1234_5678);
    add_write(3'd0, 6'd0, Q24_MAX);
    add_write(3'd6, 6'd63, Q24_MIN);
    // Zero rate, state from the register and from the transaction
    add_cfg('0, 7'd63, NEG_ONE_Q24, 7'd64);
    add_eval(48'd0, 7'h7F);
    add_eval(48'd9, 7'd0);
    // No table, largest rate: zero at step zero, saturation at the top step
    add_cfg(41'h0FF_FFFF_FFFF, START_STATE_NONE, NEG_ONE_Q24, 7'd0);
    add_checked_eval(48'd0, 7'd3, 32'd0, 1'b0);
    add_checked_eval('1, 7'd3, Q24_MAX, 1'b0);
    add_cfg({RATE_W{1'b1}}, START_STATE_NONE, 32'h0080_0000, 7'd0);
    add_eval(48'd2, 7'h7F);
    // Most negative rate from lambda one: top column, bottom column, clamp
    add_cfg(41'h100_0000_0000, START_STATE_NONE, 32'h0100_0000, 7'd64);
    add_eval(48'd0, 7'd1);
    add_eval(48'd1, 7'd1);
    add_eval('1, 7'd1);
    // Single column, start state set
    add_cfg(41'h080_0000_0000, 7'd0, 32'd0, 7'd1);
    add_eval(48'd3, 7'h7F);
    // Two columns, position from start state moving down
    add_cfg(-41'sd1073741824, 7'd1, Q24_MAX, 7'd2);
    add_eval(48'd1000, 7'd0);
    add_eval(48'd0, 7'd0);
    // Start lambda above one clamps to the top column
    add_cfg(41'd1, START_STATE_NONE, Q24_MAX, 7'd64);
    add_eval(48'd5, 7'd63);
    // Zero rate with no state passes start lambda unchanged; a given state picks a column
    add_cfg('0, START_STATE_NONE, Q24_MIN, 7'd64);
    add_checked_eval(48'd0, 7'h7F, Q24_MIN, 1'b0);
    add_eval(48'd0, 7'd63);
    add_cfg('0, START_STATE_NONE, Q24_MAX, 7'd0);
    add_checked_eval(48'd1, 7'h7F, Q24_MAX, 1'b0);

    foreach (plan_q[i]) begin
      if (plan_q[i].reconfig) begin
        apply_config(plan_q[i].rate, plan_q[i].sst, plan_q[i].slam, plan_q[i].siu);
      end else begin
        if (plan_q[i].txn.act == ACT_EVAL)
          load_missing(plan_q[i].txn.step, $signed(plan_q[i].txn.cur));
        offer_txn(plan_q[i].txn, plan_q[i].typed, plan_q[i].want_lam, plan_q[i].want_inv);
        sender_gap();
      end
    end

    for (int p = 0; p < 7; p++) begin
      if (p == 6) calm = 1'b1;
      random_phase(PHASE_ITEMS);
    end

    // Wait for every result, then let the block settle
    in_valid <= 1'b0;
    while (pending_lambdas.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0 && pending_lambdas.size() == 0) begin
      $display("[lambda_schedule_interpolator_core] OK");
    end else begin
      $display("[lambda_schedule_interpolator_core] ERROR");
    end
    $finish;
  end

  // Check accepted results in order and drive the result-side stall
  always @(posedge clk) begin : result_check
    lambda_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_lambdas.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected result: ch %0d lambda %h inv %b last %b",
                   out_channel_out, out_lambda_value, out_state_invalid, out_last);
      end else begin
        want = pending_lambdas.pop_front();
        if (out_channel_out !== want.ch || out_lambda_value !== want.lam ||
            out_state_invalid !== want.inv || out_last !== want.last) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: want ch %0d lambda %h inv %b last %b, got ch %0d lambda %h inv %b last %b",
                     want.ch, want.lam, want.inv, want.last, out_channel_out,
                     out_lambda_value, out_state_invalid, out_last);
        end
      end
    end

    // Hold off once for a long stretch, otherwise stall in short bursts
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (burst_left > 0) begin
      burst_left <= burst_left - 1;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      burst_left <= $urandom_range(0, 18);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("[lambda_schedule_interpolator_core] ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule
